@@ rtl/vtpy_pkg.sv @@
// Shared constants, tables and selection codes of the vector to pitch and yaw unit.
package vtpy_pkg;

  localparam int GUARD_BITS  = 8;
  localparam int TAB_FRAC    = 20;
  localparam int ACC_W       = 32;
  localparam int GAIN_W      = 30;
  localparam int GAIN_SPLIT  = 15;
  localparam int YAW_SEL_W   = 3;
  localparam int PITCH_SEL_W = 2;
  localparam int MAX_STAGES  = 32;

  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

  localparam int DEG_90  = 90;
  localparam int DEG_180 = 180;
  localparam int DEG_270 = 270;
  localparam int DEG_360 = 360;

  // Arctangent of two to the minus i, in degrees with twenty fractional bits.
  localparam logic signed [ACC_W-1:0] ATAN_Q20 [0:MAX_STAGES-1] = '{
    32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
    32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
    32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
    32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
    32'sd917,      32'sd458,      32'sd229,      32'sd115,
    32'sd57,       32'sd29,       32'sd14,       32'sd7,
    32'sd4,        32'sd2,        32'sd1,        32'sd0,
    32'sd0,        32'sd0,        32'sd0,        32'sd0
  };

  typedef enum logic [YAW_SEL_W-1:0] {
    YAW_CORDIC,
    YAW_ZERO,
    YAW_90,
    YAW_180,
    YAW_270
  } yaw_sel_e;

  typedef enum logic [PITCH_SEL_W-1:0] {
    PITCH_CORDIC,
    PITCH_ZERO,
    PITCH_90,
    PITCH_270
  } pitch_sel_e;

endpackage

@@ rtl/vtpy_cordic_cell.sv @@
// One vectoring CORDIC micro-rotation stage with its own pipeline register.
module vtpy_cordic_cell #(
  parameter int W      = 35,
  parameter int SIDE_W = 8,
  parameter int STAGE  = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [W-1:0]               x_i,
  input  logic signed [W-1:0]               y_i,
  input  logic signed [vtpy_pkg::ACC_W-1:0] acc_i,
  input  logic        [SIDE_W-1:0]          side_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [W-1:0]               x_o,
  output logic signed [W-1:0]               y_o,
  output logic signed [vtpy_pkg::ACC_W-1:0] acc_o,
  output logic        [SIDE_W-1:0]          side_o
);

  logic                              valid_q;
  logic signed [W-1:0]               x_q, x_d, y_q, y_d;
  logic signed [vtpy_pkg::ACC_W-1:0] acc_q, acc_d;
  logic        [SIDE_W-1:0]          side_q;
  logic signed [W-1:0]               dx, dy;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
    if (!y_i[W-1]) begin
      x_d   = x_i + dx;
      y_d   = y_i - dy;
      acc_d = acc_i + vtpy_pkg::ATAN_Q20[STAGE];
    end else begin
      x_d   = x_i - dx;
      y_d   = y_i + dy;
      acc_d = acc_i - vtpy_pkg::ATAN_Q20[STAGE];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      x_q    <= x_d;
      y_q    <= y_d;
      acc_q  <= acc_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign acc_o   = acc_q;
  assign side_o  = side_q;

endmodule

@@ rtl/vtpy_gain_cell.sv @@
// Two-stage CORDIC gain correction of the horizontal length.
module vtpy_gain_cell #(
  parameter int W      = 35,
  parameter int SIDE_W = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic signed [W-1:0] x_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic signed [W-1:0] x_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int SPLIT = vtpy_pkg::GAIN_SPLIT;
  localparam int GW    = vtpy_pkg::GAIN_W;
  localparam int HI_W  = W - 1 - SPLIT;
  localparam int HP_W  = HI_W + GW;
  localparam int LP_W  = SPLIT + GW;
  localparam int SUM_W = HP_W + 1;

  logic              mul_valid_q, out_valid_q, out_ready;
  logic [HP_W-1:0]   hi_prod_q;
  logic [LP_W-1:0]   lo_prod_q;
  logic [SIDE_W-1:0] mul_side_q, out_side_q;
  logic [SUM_W-1:0]  sum;
  logic [W-1:0]      x_q;

  assign out_ready = !out_valid_q || ready_i;
  assign ready_o   = !mul_valid_q || out_ready;

  assign sum = {1'b0, hi_prod_q} + SUM_W'(lo_prod_q >> SPLIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        mul_valid_q <= valid_i;
      end
      if (out_ready) begin
        out_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      hi_prod_q  <= HP_W'(x_i[W-2:SPLIT]) * HP_W'(vtpy_pkg::GAIN_Q30);
      lo_prod_q  <= LP_W'(x_i[SPLIT-1:0]) * LP_W'(vtpy_pkg::GAIN_Q30);
      mul_side_q <= side_i;
    end
    if (mul_valid_q && out_ready) begin
      x_q        <= sum[SUM_W-1:SPLIT];
      out_side_q <= mul_side_q;
    end
  end

  assign valid_o = out_valid_q;
  assign x_o     = x_q;
  assign side_o  = out_side_q;

endmodule

@@ rtl/vtpy_exit_cell.sv @@
// Output stage: angle rounding, wrap into one turn, special cases and pitch negation.
module vtpy_exit_cell #(
  parameter int F = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [vtpy_pkg::ACC_W-1:0] yaw_acc_i,
  input  logic signed [vtpy_pkg::ACC_W-1:0] pitch_acc_i,
  input  vtpy_pkg::yaw_sel_e                yaw_sel_i,
  input  vtpy_pkg::pitch_sel_e              pitch_sel_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [F+9:0]               pitch_o,
  output logic        [F+8:0]               yaw_o
);

  localparam int AW = vtpy_pkg::ACC_W;
  localparam int S  = vtpy_pkg::TAB_FRAC - F;
  localparam logic signed [AW-1:0] FULL = AW'(vtpy_pkg::DEG_360) <<< F;
  localparam logic signed [AW-1:0] HALF = (S > 0) ? (AW'(1) <<< ((S > 0) ? S - 1 : 0)) : '0;

  function automatic logic signed [AW-1:0] wrap_angle(input logic signed [AW-1:0] acc);
    logic signed [AW-1:0] r;
    r = (acc + HALF) >>> S;
    if (r < 0) begin
      r = r + FULL;
    end else if (r >= FULL) begin
      r = r - FULL;
    end
    return r;
  endfunction

  logic                 valid_q;
  logic signed [AW-1:0] yaw_d, pitch_d;
  logic [F+8:0]         yaw_q;
  logic signed [F+9:0]  pitch_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    unique case (yaw_sel_i)
      vtpy_pkg::YAW_CORDIC: yaw_d = wrap_angle(yaw_acc_i);
      vtpy_pkg::YAW_ZERO:   yaw_d = '0;
      vtpy_pkg::YAW_90:     yaw_d = AW'(vtpy_pkg::DEG_90) <<< F;
      vtpy_pkg::YAW_180:    yaw_d = AW'(vtpy_pkg::DEG_180) <<< F;
      vtpy_pkg::YAW_270:    yaw_d = AW'(vtpy_pkg::DEG_270) <<< F;
      default:              yaw_d = '0;
    endcase
    unique case (pitch_sel_i)
      vtpy_pkg::PITCH_CORDIC: pitch_d = wrap_angle(pitch_acc_i);
      vtpy_pkg::PITCH_ZERO:   pitch_d = '0;
      vtpy_pkg::PITCH_90:     pitch_d = AW'(vtpy_pkg::DEG_90) <<< F;
      vtpy_pkg::PITCH_270:    pitch_d = AW'(vtpy_pkg::DEG_270) <<< F;
      default:                pitch_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      yaw_q   <= yaw_d[F+8:0];
      pitch_q <= -pitch_d[F+9:0];
    end
  end

  assign valid_o = valid_q;
  assign yaw_o   = yaw_q;
  assign pitch_o = pitch_q;

endmodule

@@ rtl/vector_to_pitch_yaw_unit.sv @@
// Top level: direction vector to yaw and negated pitch through two CORDIC cell chains.
//
// The input channel (in_valid_i, in_ready_o) carries one direction vector per
// transaction as three signed components. The output channel (out_valid_o,
// out_ready_i) carries yaw in [0, 360) and the negated pitch in (-360, 0], both
// in degrees with ANGLE_FRAC_BITS fractional bits.
// Every cell holds one vector and passes it on each cycle unless stalled, so
// one transaction is accepted per clock while the receiver keeps up. On its way
// a vector passes an entry register, the yaw rotation chain, two gain
// correction stages, the pitch rotation chain and the output register. Each
// cell moves on whenever the cell after it is empty or moving, so gaps close
// up. When the receiver stalls, the result waits in the output register and
// the chain keeps taking transactions until every cell is full; only then does
// in_ready_o fall. Reset empties all cells at once, dropping items in flight
// and producing none; the block is ready in the first cycle after reset.
module vector_to_pitch_yaw_unit #(
  parameter int COMPONENT_WIDTH = 24,
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int CORDIC_STAGES   = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COMPONENT_WIDTH-1:0] vec_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] vec_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] vec_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ANGLE_FRAC_BITS+9:0] pitch_deg_o,
  output logic        [ANGLE_FRAC_BITS+8:0] yaw_deg_o
);

  localparam int CW     = COMPONENT_WIDTH;
  localparam int F      = ANGLE_FRAC_BITS;
  localparam int W      = CW + vtpy_pkg::GUARD_BITS + 3;
  localparam int AW     = vtpy_pkg::ACC_W;
  localparam int N      = (CORDIC_STAGES > vtpy_pkg::MAX_STAGES) ?
                          vtpy_pkg::MAX_STAGES : CORDIC_STAGES;
  localparam int SEL_W  = vtpy_pkg::YAW_SEL_W + vtpy_pkg::PITCH_SEL_W;
  localparam int SIDE1  = SEL_W + W;
  localparam int SIDEG  = SIDE1 + AW;
  localparam int SIDE2  = SEL_W + AW;

  // Entry register.
  logic                 ent_valid_q;
  logic signed [W-1:0]  ent_x_q, ent_y_q, ent_z_q;
  logic signed [AW-1:0] ent_acc_q;
  vtpy_pkg::yaw_sel_e   ent_yaw_sel_q, yaw_sel_d;
  vtpy_pkg::pitch_sel_e ent_pitch_sel_q, pitch_sel_d;
  logic signed [W-1:0]  xs, ys, zs;
  logic                 x_zero, y_zero, z_zero, x_neg;

  // Yaw chain.
  logic                 p1_valid [0:N];
  logic                 p1_ready [0:N];
  logic signed [W-1:0]  p1_x     [0:N];
  logic signed [W-1:0]  p1_y     [0:N];
  logic signed [AW-1:0] p1_acc   [0:N];
  logic [SIDE1-1:0]     p1_side  [0:N];

  // Pitch chain.
  logic                 p2_valid [0:N];
  logic                 p2_ready [0:N];
  logic signed [W-1:0]  p2_x     [0:N];
  logic signed [W-1:0]  p2_y     [0:N];
  logic signed [AW-1:0] p2_acc   [0:N];
  logic [SIDE2-1:0]     p2_side  [0:N];

  logic [SIDEG-1:0]     g_side;
  logic                 ex_ready;

  always_comb begin
    xs     = W'(vec_x_i) <<< vtpy_pkg::GUARD_BITS;
    ys     = W'(vec_y_i) <<< vtpy_pkg::GUARD_BITS;
    zs     = W'(vec_z_i) <<< vtpy_pkg::GUARD_BITS;
    x_zero = (vec_x_i == '0);
    y_zero = (vec_y_i == '0);
    z_zero = (vec_z_i == '0);
    x_neg  = vec_x_i[CW-1];

    priority if (x_zero && y_zero) begin
      yaw_sel_d = vtpy_pkg::YAW_ZERO;
    end else if (x_zero) begin
      yaw_sel_d = vec_y_i[CW-1] ? vtpy_pkg::YAW_270 : vtpy_pkg::YAW_90;
    end else if (y_zero) begin
      yaw_sel_d = x_neg ? vtpy_pkg::YAW_180 : vtpy_pkg::YAW_ZERO;
    end else begin
      yaw_sel_d = vtpy_pkg::YAW_CORDIC;
    end

    priority if (x_zero && y_zero) begin
      pitch_sel_d = (!z_zero && !vec_z_i[CW-1]) ? vtpy_pkg::PITCH_90 : vtpy_pkg::PITCH_270;
    end else if (z_zero) begin
      pitch_sel_d = vtpy_pkg::PITCH_ZERO;
    end else begin
      pitch_sel_d = vtpy_pkg::PITCH_CORDIC;
    end
  end

  assign in_ready_o = !ent_valid_q || p1_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      ent_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ent_x_q         <= x_neg ? -xs : xs;
      ent_y_q         <= x_neg ? -ys : ys;
      ent_z_q         <= zs;
      ent_acc_q       <= x_neg ? (AW'(vtpy_pkg::DEG_180) <<< vtpy_pkg::TAB_FRAC) : '0;
      ent_yaw_sel_q   <= yaw_sel_d;
      ent_pitch_sel_q <= pitch_sel_d;
    end
  end

  assign p1_valid[0] = ent_valid_q;
  assign p1_x[0]     = ent_x_q;
  assign p1_y[0]     = ent_y_q;
  assign p1_acc[0]   = ent_acc_q;
  assign p1_side[0]  = {ent_pitch_sel_q, ent_yaw_sel_q, ent_z_q};

  for (genvar i = 0; i < N; i++) begin : g_yaw
    vtpy_cordic_cell #(
      .W      (W),
      .SIDE_W (SIDE1),
      .STAGE  (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (p1_valid[i]),
      .ready_o (p1_ready[i]),
      .x_i     (p1_x[i]),
      .y_i     (p1_y[i]),
      .acc_i   (p1_acc[i]),
      .side_i  (p1_side[i]),
      .valid_o (p1_valid[i+1]),
      .ready_i (p1_ready[i+1]),
      .x_o     (p1_x[i+1]),
      .y_o     (p1_y[i+1]),
      .acc_o   (p1_acc[i+1]),
      .side_o  (p1_side[i+1])
    );
  end

  vtpy_gain_cell #(
    .W      (W),
    .SIDE_W (SIDEG)
  ) u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p1_valid[N]),
    .ready_o (p1_ready[N]),
    .x_i     (p1_x[N]),
    .side_i  ({p1_side[N], p1_acc[N]}),
    .valid_o (p2_valid[0]),
    .ready_i (p2_ready[0]),
    .x_o     (p2_x[0]),
    .side_o  (g_side)
  );

  assign p2_y[0]    = g_side[AW+W-1:AW];
  assign p2_acc[0]  = '0;
  assign p2_side[0] = {g_side[SIDEG-1:AW+W], g_side[AW-1:0]};

  for (genvar i = 0; i < N; i++) begin : g_pitch
    vtpy_cordic_cell #(
      .W      (W),
      .SIDE_W (SIDE2),
      .STAGE  (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (p2_valid[i]),
      .ready_o (p2_ready[i]),
      .x_i     (p2_x[i]),
      .y_i     (p2_y[i]),
      .acc_i   (p2_acc[i]),
      .side_i  (p2_side[i]),
      .valid_o (p2_valid[i+1]),
      .ready_i (p2_ready[i+1]),
      .x_o     (p2_x[i+1]),
      .y_o     (p2_y[i+1]),
      .acc_o   (p2_acc[i+1]),
      .side_o  (p2_side[i+1])
    );
  end

  assign p2_ready[N] = ex_ready;

  vtpy_exit_cell #(
    .F (F)
  ) u_exit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (p2_valid[N]),
    .ready_o     (ex_ready),
    .yaw_acc_i   (p2_side[N][AW-1:0]),
    .pitch_acc_i (p2_acc[N]),
    .yaw_sel_i   (vtpy_pkg::yaw_sel_e'(p2_side[N][AW+vtpy_pkg::YAW_SEL_W-1:AW])),
    .pitch_sel_i (vtpy_pkg::pitch_sel_e'(p2_side[N][SIDE2-1:AW+vtpy_pkg::YAW_SEL_W])),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .pitch_o     (pitch_deg_o),
    .yaw_o       (yaw_deg_o)
  );

`ifndef SYNTH
  localparam logic [F+8:0]        YAW_FULL  = (F+9)'(vtpy_pkg::DEG_360) << F;
  localparam logic signed [F+9:0] PITCH_LOW = -((F+10)'(vtpy_pkg::DEG_360) <<< F);

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (yaw_deg_o < YAW_FULL))
    else $error("Yaw result outside one turn.");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pitch_deg_o <= 0) && (pitch_deg_o > PITCH_LOW))
    else $error("Negated pitch result outside one turn.");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("Input stalled while the output side was free.");
`endif

endmodule

@@ verif/pyu_tb_pkg.sv @@
// Angle predictor and scoreboard for the vector to pitch and yaw unit testbench.
package pyu_tb_pkg;

  localparam int COMP_W   = 24;
  localparam int FRAC_W   = 16;
  localparam int N_STAGES = 20;

  localparam int RUN_STAGES    = (N_STAGES > 32) ? 32 : N_STAGES;
  localparam int GUARD         = 8;
  localparam int ACC_FRAC      = 20;
  localparam int GAIN_SPLIT    = 15;
  localparam int MAX_REPORTED  = 40;

  localparam longint unsigned CORDIC_GAIN_Q30 = 64'd652032874;

  localparam longint ARCTAN_Q20 [0:31] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682,   117342,   58671,    29335,   14668,   7334,    3667,   1833,
    917,      458,      229,      115,     57,      29,      14,     7,
    4,        2,        1,        0,       0,       0,       0,      0
  };

  typedef struct packed {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
    logic signed [FRAC_W+9:0] pitch;
    logic        [FRAC_W+8:0] yaw;
  } angles_t;

  class pitch_yaw_scoreboard;
    angles_t     expected_angles[$];
    int unsigned vectors_noted   = 0;
    int unsigned special_noted   = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches      = 0;

    function longint turn_to_axis(inout longint cx, inout longint cy);
      longint swept = 0;
      longint dx, dy;
      for (int i = 0; i < RUN_STAGES; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx += dx;
          cy -= dy;
          swept += ARCTAN_Q20[i];
        end else begin
          cx -= dx;
          cy += dy;
          swept -= ARCTAN_Q20[i];
        end
      end
      return swept;
    endfunction

    function longint scale_angle(longint acc);
      longint full = longint'(vtpy_pkg::DEG_360) <<< FRAC_W;
      longint r;
      r = (acc + (longint'(1) <<< (ACC_FRAC - FRAC_W - 1))) >>> (ACC_FRAC - FRAC_W);
      if (r < 0) r += full;
      if (r >= full) r -= full;
      return r;
    endfunction

    function longint horizontal_length(longint h);
      longint unsigned u = h;
      longint unsigned hi, lo;
      hi = u >> GAIN_SPLIT;
      lo = u & ((64'd1 << GAIN_SPLIT) - 64'd1);
      return longint'((hi * CORDIC_GAIN_Q30 + ((lo * CORDIC_GAIN_Q30) >> GAIN_SPLIT))
                      >> GAIN_SPLIT);
    endfunction

    function angles_t predict_angles(logic signed [COMP_W-1:0] x,
                                     logic signed [COMP_W-1:0] y,
                                     logic signed [COMP_W-1:0] z);
      angles_t res;
      longint  vx = x;
      longint  vy = y;
      longint  vz = z;
      longint  hx, hy, lx, lz, turned, yaw_v, pitch_v, neg_pitch;
      res.x = x;
      res.y = y;
      res.z = z;
      if (vx == 0 && vy == 0) begin
        yaw_v   = 0;
        pitch_v = longint'(vz > 0 ? vtpy_pkg::DEG_90 : vtpy_pkg::DEG_270) <<< FRAC_W;
      end else begin
        hx     = vx <<< GUARD;
        hy     = vy <<< GUARD;
        turned = 0;
        if (hx < 0) begin
          hx     = -hx;
          hy     = -hy;
          turned = longint'(vtpy_pkg::DEG_180) <<< ACC_FRAC;
        end
        turned += turn_to_axis(hx, hy);
        if (vx == 0) begin
          yaw_v = longint'(vy > 0 ? vtpy_pkg::DEG_90 : vtpy_pkg::DEG_270) <<< FRAC_W;
        end else if (vy == 0) begin
          yaw_v = longint'(vx > 0 ? 0 : vtpy_pkg::DEG_180) <<< FRAC_W;
        end else begin
          yaw_v = scale_angle(turned);
        end
        if (vz == 0) begin
          pitch_v = 0;
        end else begin
          lx      = horizontal_length(hx);
          lz      = vz <<< GUARD;
          pitch_v = scale_angle(turn_to_axis(lx, lz));
        end
      end
      neg_pitch = -pitch_v;
      res.pitch = neg_pitch[FRAC_W+9:0];
      res.yaw   = yaw_v[FRAC_W+8:0];
      return res;
    endfunction

    function void note_vector(logic signed [COMP_W-1:0] x,
                              logic signed [COMP_W-1:0] y,
                              logic signed [COMP_W-1:0] z);
      expected_angles.push_back(predict_angles(x, y, z));
      vectors_noted++;
      if (x == 0 || y == 0 || z == 0) special_noted++;
    endfunction

    task report(string what);
      if (mismatches < MAX_REPORTED) $display("MISMATCH %s", what);
      mismatches++;
    endtask

    task check_result(logic signed [FRAC_W+9:0] pitch, logic [FRAC_W+8:0] yaw);
      angles_t want;
      if (expected_angles.size() == 0) begin
        report($sformatf("unexpected result: pitch %0d yaw %0d", pitch, yaw));
        return;
      end
      want = expected_angles.pop_front();
      results_checked++;
      if (pitch !== want.pitch)
        report($sformatf("vector (%0d, %0d, %0d): pitch %0d, expected %0d",
                         want.x, want.y, want.z, pitch, want.pitch));
      if (yaw !== want.yaw)
        report($sformatf("vector (%0d, %0d, %0d): yaw %0d, expected %0d",
                         want.x, want.y, want.z, yaw, want.yaw));
    endtask
  endclass

endpackage

@@ verif/tb_top.sv @@
// Testbench top: streams direction vectors through the unit and checks every angle pair.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          COMP_W         = pyu_tb_pkg::COMP_W;
  localparam int          FRAC_W         = pyu_tb_pkg::FRAC_W;
  localparam int          N_STAGES       = pyu_tb_pkg::N_STAGES;
  localparam int          HALF_PERIOD    = 5;
  localparam int          RESET_CYCLES   = 10;
  localparam int          RANDOM_VECTORS = 1230;
  localparam int          DRAIN_CYCLES   = 2 * N_STAGES + 12;
  localparam int unsigned CYCLE_LIMIT    = 500000;
  localparam int          COMP_MAX       = (1 <<< (COMP_W - 1)) - 1;
  localparam int          COMP_MIN       = -(1 <<< (COMP_W - 1));

  typedef enum int {ACCEPT_ALL, ACCEPT_MOST, ACCEPT_FEW, ACCEPT_RARE} sink_mode_e;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic signed [COMP_W-1:0] vec_x_i     = '0;
  logic signed [COMP_W-1:0] vec_y_i     = '0;
  logic signed [COMP_W-1:0] vec_z_i     = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [FRAC_W+9:0] pitch_deg_o;
  logic        [FRAC_W+8:0] yaw_deg_o;

  pyu_tb_pkg::pitch_yaw_scoreboard sb = new;

  int unsigned burst_left = 0;
  sink_mode_e  sink_mode  = ACCEPT_ALL;
  int unsigned mode_left  = 0;
  int unsigned cycle_count = 0;

  vector_to_pitch_yaw_unit #(
    .COMPONENT_WIDTH(COMP_W),
    .ANGLE_FRAC_BITS(FRAC_W),
    .CORDIC_STAGES  (N_STAGES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .vec_x_i    (vec_x_i),
    .vec_y_i    (vec_y_i),
    .vec_z_i    (vec_z_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pitch_deg_o(pitch_deg_o),
    .yaw_deg_o  (yaw_deg_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic int random_component();
    int r;
    r = int'($urandom);
    case ($urandom_range(0, 9))
      0: return 0;
      1: begin
        case ($urandom_range(0, 3))
          0: return COMP_MAX;
          1: return COMP_MIN;
          2: return 1;
          default: return -1;
        endcase
      end
      2, 3: return int'($urandom_range(0, 255)) - 128;
      4: return int'($urandom_range(0, 131071)) - 65536;
      default: return (r <<< (32 - COMP_W)) >>> (32 - COMP_W);
    endcase
  endfunction

  task automatic send_vector(input int x, input int y, input int z);
    int unsigned gap;
    in_valid_i <= 1'b1;
    vec_x_i    <= x[COMP_W-1:0];
    vec_y_i    <= y[COMP_W-1:0];
    vec_z_i    <= z[COMP_W-1:0];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_vector(vec_x_i, vec_y_i, vec_z_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 30);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(pitch_deg_o, yaw_deg_o);
    if (mode_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    case (sink_mode)
      ACCEPT_ALL:  out_ready_i <= 1'b1;
      ACCEPT_MOST: out_ready_i <= ($urandom_range(0, 3) != 0);
      ACCEPT_FEW:  out_ready_i <= ($urandom_range(0, 3) == 0);
      default:     out_ready_i <= ($urandom_range(0, 19) == 0);
    endcase
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run timed out after %0d cycles.", cycle_count);
    $display("[vector_to_pitch_yaw_unit] ERROR");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_vector(0, 0, 0);
    send_vector(0, 0, 1);
    send_vector(0, 0, -1);
    send_vector(0, 0, COMP_MAX);
    send_vector(0, 0, COMP_MIN);
    send_vector(0, 5, 3);
    send_vector(0, COMP_MIN, 0);
    send_vector(0, COMP_MAX, COMP_MIN);
    send_vector(100, 0, -7);
    send_vector(COMP_MIN, 0, COMP_MAX);
    send_vector(1, 0, 0);
    send_vector(COMP_MAX, COMP_MAX, COMP_MAX);
    send_vector(COMP_MIN, COMP_MIN, COMP_MIN);
    send_vector(COMP_MAX, COMP_MIN, 0);
    send_vector(COMP_MIN, COMP_MAX, 1);
    send_vector(1, 1, 1);
    send_vector(-1, -1, -1);
    send_vector(1, -1, 0);
    send_vector(-1, 1, COMP_MAX);
    send_vector(3, 4, 5);
    send_vector(COMP_MAX, 1, -1);
    send_vector(-1, COMP_MAX, COMP_MIN);

    for (int n = 0; n < RANDOM_VECTORS; n++)
      send_vector(random_component(), random_component(), random_component());

    if (in_valid_i) in_valid_i <= 1'b0;
    while (sb.expected_angles.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d vectors, %0d of them with a zero component, over %0d cycles.",
             sb.vectors_noted, sb.special_noted, cycle_count);
    $display("Checked %0d angle pairs under varying stalls; %0d mismatches.",
             sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[vector_to_pitch_yaw_unit] OK");
    end else begin
      $display("[vector_to_pitch_yaw_unit] ERROR");
    end
    $finish;
  end

endmodule
